### design/haversine_distance_defines.svh
// ----------------------------------------------------------------------------
// haversine_distance_defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef HAVERSINE_DISTANCE_DEFINES_SVH
`define HAVERSINE_DISTANCE_DEFINES_SVH

// same-cycle implication
`define HD_ASSERT_NOW(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HD_ASSERT_NXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/hd_pkg.sv
// ----------------------------------------------------------------------------
// hd_pkg
// types, fixed-point constants and arctangent table of the haversine pipeline
// ----------------------------------------------------------------------------
package hd_pkg;

	localparam int NSTEP = 31;
	localparam int NLANE = 4;
	localparam int NSQ   = 2;
	localparam int ANG_W = 34;
	localparam int CW    = 34;
	localparam int TW    = 32;
	localparam int AW    = 31;
	localparam int RW    = 31;

	localparam logic [ANG_W-1:0] PI_Q30      = 34'd3373259426;
	localparam logic [ANG_W-1:0] TWO_PI_Q30  = 34'd6746518852;
	localparam logic [ANG_W-1:0] HALF_PI_Q30 = 34'd1686629713;
	localparam logic [32:0]      DEG2RAD_Q38 = 33'd4797524517;
	localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam logic [AW-1:0]    ONE_Q30      = 31'd1073741824;
	localparam logic [28:0]      KM_SCALE_Q16 = 29'd492685230;
	localparam logic [30:0]      DIST_MAX     = 31'd1547829248;

	// atan(2^-i) in Q30
	localparam logic [29:0] ATAN_Q30 [NSTEP] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
		30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
		30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
		30'd262144,    30'd131072,    30'd65536,     30'd32768,
		30'd16384,     30'd8192,      30'd4096,      30'd2048,
		30'd1024,      30'd512,       30'd256,       30'd128,
		30'd64,        30'd32,        30'd16,        30'd8,
		30'd4,         30'd2,         30'd1
	};

	typedef enum logic {
		LANE_SIN,
		LANE_COS
	} lane_kind_t;

	// lanes: half lat difference, half lon difference, lat a, lat b
	localparam lane_kind_t LANE_KIND [NLANE] = '{LANE_SIN, LANE_SIN, LANE_COS, LANE_COS};

	typedef logic [ANG_W-1:0]     angle_t;
	typedef logic signed [TW-1:0] trig_t;

	typedef struct packed {
		logic en;
		logic vld;
	} pipe_ctl_t;

endpackage

### design/hd_trig.sv
// ----------------------------------------------------------------------------
// hd_trig
// four-lane sine/cosine: quadrant folding then pipelined rotation cordic
// ----------------------------------------------------------------------------
module hd_trig (
	input  logic               clk,
	input  logic               arst_n,
	input  hd_pkg::pipe_ctl_t  ctl,
	input  hd_pkg::angle_t     ang [hd_pkg::NLANE],
	output logic               out_vld,
	output hd_pkg::trig_t      res [hd_pkg::NLANE]
);
	import hd_pkg::*;

	angle_t                r_s1 [NLANE];
	logic                  vld_s1;
	logic signed [CW-1:0]  z_s2 [NLANE];
	logic                  neg_s2 [NLANE];
	logic                  vld_s2;
	logic signed [CW-1:0]  cx_s [NSTEP][NLANE];
	logic signed [CW-1:0]  cy_s [NSTEP][NLANE];
	logic signed [CW-1:0]  cz_s [NSTEP][NLANE];
	logic                  cn_s [NSTEP][NLANE];
	logic                  cv_s [NSTEP];
	trig_t                 res_s3 [NLANE];
	logic                  vld_s3;
	logic signed [CW-1:0]  negx [NLANE];

	// fold into [0, pi]; inputs never reach 2pi
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (ctl.en) begin
			vld_s1 <= ctl.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= cv_s[NSTEP-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int l = 0; l < NLANE; l++) begin
				r_s1[l] <= (ang[l] > PI_Q30) ? TWO_PI_Q30 - ang[l] : ang[l];
				if (r_s1[l] > HALF_PI_Q30) begin
					z_s2[l]   <= $signed(PI_Q30 - r_s1[l]);
					neg_s2[l] <= 1'b1;
				end else begin
					z_s2[l]   <= $signed(r_s1[l]);
					neg_s2[l] <= 1'b0;
				end
			end
		end
	end

	for (genvar g = 0; g < NSTEP; g++) begin : g_step
		logic signed [CW-1:0] xi [NLANE];
		logic signed [CW-1:0] yi [NLANE];
		logic signed [CW-1:0] zi [NLANE];
		logic                 ni [NLANE];
		logic                 vi;
		logic signed [CW-1:0] tab;

		assign tab = $signed({{(CW-30){1'b0}}, ATAN_Q30[g]});

		if (g == 0) begin : g_first
			always_comb begin
				for (int l = 0; l < NLANE; l++) begin
					xi[l] = CORDIC_GAIN_Q30;
					yi[l] = '0;
					zi[l] = z_s2[l];
					ni[l] = neg_s2[l];
				end
				vi = vld_s2;
			end
		end else begin : g_next
			always_comb begin
				for (int l = 0; l < NLANE; l++) begin
					xi[l] = cx_s[g-1][l];
					yi[l] = cy_s[g-1][l];
					zi[l] = cz_s[g-1][l];
					ni[l] = cn_s[g-1][l];
				end
				vi = cv_s[g-1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[g] <= 1'b0;
			end else if (ctl.en) begin
				cv_s[g] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				for (int l = 0; l < NLANE; l++) begin
					cn_s[g][l] <= ni[l];
					if (!zi[l][CW-1]) begin
						cx_s[g][l] <= xi[l] - (yi[l] >>> g);
						cy_s[g][l] <= yi[l] + (xi[l] >>> g);
						cz_s[g][l] <= zi[l] - tab;
					end else begin
						cx_s[g][l] <= xi[l] + (yi[l] >>> g);
						cy_s[g][l] <= yi[l] - (xi[l] >>> g);
						cz_s[g][l] <= zi[l] + tab;
					end
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < NLANE; l++) begin
			negx[l] = cn_s[NSTEP-1][l] ? -cx_s[NSTEP-1][l] : cx_s[NSTEP-1][l];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int l = 0; l < NLANE; l++) begin
				if (LANE_KIND[l] == LANE_SIN) begin
					res_s3[l] <= cy_s[NSTEP-1][l][TW-1:0];
				end else begin
					res_s3[l] <= negx[l][TW-1:0];
				end
			end
		end
	end

	assign out_vld = vld_s3;
	assign res     = res_s3;

endmodule

### design/hd_isqrt.sv
// ----------------------------------------------------------------------------
// hd_isqrt
// two-lane floor square root of a Q30 value, one result bit per stage
// ----------------------------------------------------------------------------
module hd_isqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  hd_pkg::pipe_ctl_t         ctl,
	input  logic [hd_pkg::AW-1:0]     a_in [hd_pkg::NSQ],
	output logic                      out_vld,
	output logic [hd_pkg::RW-1:0]     root [hd_pkg::NSQ]
);
	import hd_pkg::*;

	localparam int VW  = 2 * RW;
	localparam int RMW = RW + 3;

	logic [VW-1:0]  v_s [RW][NSQ];
	logic [RMW-1:0] rem_s [RW][NSQ];
	logic [RW-1:0]  rt_s [RW][NSQ];
	logic           sv_s [RW];

	for (genvar g = 0; g < RW; g++) begin : g_step
		logic [VW-1:0]  vi [NSQ];
		logic [RMW-1:0] ri [NSQ];
		logic [RW-1:0]  qi [NSQ];
		logic           vld_i;
		logic [RMW-1:0] remn [NSQ];
		logic [RMW-1:0] trial [NSQ];

		if (g == 0) begin : g_first
			always_comb begin
				for (int l = 0; l < NSQ; l++) begin
					vi[l] = {{(VW-AW-30){1'b0}}, a_in[l], 30'b0};
					ri[l] = '0;
					qi[l] = '0;
				end
				vld_i = ctl.vld;
			end
		end else begin : g_next
			always_comb begin
				for (int l = 0; l < NSQ; l++) begin
					vi[l] = v_s[g-1][l];
					ri[l] = rem_s[g-1][l];
					qi[l] = rt_s[g-1][l];
				end
				vld_i = sv_s[g-1];
			end
		end

		always_comb begin
			for (int l = 0; l < NSQ; l++) begin
				remn[l]  = {ri[l][RMW-3:0], vi[l][VW-1 -: 2]};
				trial[l] = {{(RMW-RW-2){1'b0}}, qi[l], 2'b01};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv_s[g] <= 1'b0;
			end else if (ctl.en) begin
				sv_s[g] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				for (int l = 0; l < NSQ; l++) begin
					v_s[g][l] <= {vi[l][VW-3:0], 2'b00};
					if (remn[l] >= trial[l]) begin
						rem_s[g][l] <= remn[l] - trial[l];
						rt_s[g][l]  <= {qi[l][RW-2:0], 1'b1};
					end else begin
						rem_s[g][l] <= remn[l];
						rt_s[g][l]  <= {qi[l][RW-2:0], 1'b0};
					end
				end
			end
		end
	end

	assign out_vld = sv_s[RW-1];
	assign root    = rt_s[RW-1];

endmodule

### design/hd_atan.sv
// ----------------------------------------------------------------------------
// hd_atan
// pipelined vectoring cordic giving atan2(y, x) in Q30 radians
// ----------------------------------------------------------------------------
module hd_atan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hd_pkg::pipe_ctl_t             ctl,
	input  logic [hd_pkg::RW-1:0]         x_in,
	input  logic [hd_pkg::RW-1:0]         y_in,
	output logic                          out_vld,
	output logic signed [hd_pkg::CW-1:0]  z_out
);
	import hd_pkg::*;

	logic signed [CW-1:0] vx_s [NSTEP];
	logic signed [CW-1:0] vy_s [NSTEP];
	logic signed [CW-1:0] vz_s [NSTEP];
	logic                 vv_s [NSTEP];

	for (genvar g = 0; g < NSTEP; g++) begin : g_step
		logic signed [CW-1:0] xi;
		logic signed [CW-1:0] yi;
		logic signed [CW-1:0] zi;
		logic                 vi;
		logic signed [CW-1:0] tab;

		assign tab = $signed({{(CW-30){1'b0}}, ATAN_Q30[g]});

		if (g == 0) begin : g_first
			assign xi = $signed({{(CW-RW){1'b0}}, x_in});
			assign yi = $signed({{(CW-RW){1'b0}}, y_in});
			assign zi = '0;
			assign vi = ctl.vld;
		end else begin : g_next
			assign xi = vx_s[g-1];
			assign yi = vy_s[g-1];
			assign zi = vz_s[g-1];
			assign vi = vv_s[g-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vv_s[g] <= 1'b0;
			end else if (ctl.en) begin
				vv_s[g] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				if (!yi[CW-1] && (yi != '0)) begin
					vx_s[g] <= xi + (yi >>> g);
					vy_s[g] <= yi - (xi >>> g);
					vz_s[g] <= zi + tab;
				end else begin
					vx_s[g] <= xi - (yi >>> g);
					vy_s[g] <= yi + (xi >>> g);
					vz_s[g] <= zi - tab;
				end
			end
		end
	end

	assign out_vld = vv_s[NSTEP-1];
	assign z_out   = vz_s[NSTEP-1];

endmodule

### design/haversine_distance.sv
// ----------------------------------------------------------------------------
// haversine_distance
// throughput: one beat per cycle; the whole pipeline holds while an output
// beat waits under stall, so in_stall follows out_stall of a valid result
// reset: arst_n clears every valid bit at once; no clearing pass
// ----------------------------------------------------------------------------
module haversine_distance (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [27:0] lat_a,
	input  logic signed [28:0] lon_a,
	input  logic signed [27:0] lat_b,
	input  logic signed [28:0] lon_b,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [30:0]        distance_km
);
	import hd_pkg::*;

	logic               pipe_en;
	logic signed [28:0] dlat;
	logic signed [29:0] dlon;
	logic [28:0]        mlat_s1;
	logic [29:0]        mlon_s1;
	logic [27:0]        mla_s1;
	logic [27:0]        mlb_s1;
	logic               vld_s1;
	logic [62:0]        p_dlat;
	logic [62:0]        p_dlon;
	logic [62:0]        p_la;
	logic [62:0]        p_lb;
	angle_t             ang_s2 [NLANE];
	logic               vld_s2;
	pipe_ctl_t          trig_ctl;
	trig_t              trig [NLANE];
	logic               trig_vld;
	logic signed [63:0] sq_lat;
	logic signed [63:0] sq_lon;
	logic signed [63:0] cos_pr;
	logic signed [TW-1:0] s1sq_s3;
	logic signed [TW-1:0] s2sq_s3;
	logic signed [TW-1:0] cc_s3;
	logic               vld_s3;
	logic signed [63:0] term_pr;
	logic signed [TW-1:0] s1sq_s4;
	logic signed [TW-1:0] term_s4;
	logic               vld_s4;
	logic signed [TW:0] a_sum;
	logic [AW-1:0]      a_clamp;
	logic [AW-1:0]      sq_in_s5 [NSQ];
	logic               vld_s5;
	pipe_ctl_t          sq_ctl;
	logic [RW-1:0]      roots [NSQ];
	logic               sq_vld;
	pipe_ctl_t          at_ctl;
	logic signed [CW-1:0] at_z;
	logic               at_vld;
	logic [32:0]        c_ang;
	logic [61:0]        prod_s6;
	logic               vld_s6;
	logic [61:0]        d_rnd;
	logic [31:0]        d_km;
	logic [30:0]        dist_s7;
	logic               vld_s7;

	assign pipe_en   = !(vld_s7 && out_stall);
	assign in_stall  = !pipe_en;
	assign out_valid = vld_s7;
	assign distance_km = dist_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (pipe_en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= trig_vld;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= at_vld;
			vld_s7 <= vld_s6;
		end
	end

	// angle magnitudes
	assign dlat = $signed({lat_b[27], lat_b}) - $signed({lat_a[27], lat_a});
	assign dlon = $signed({lon_b[28], lon_b}) - $signed({lon_a[28], lon_a});

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			mlat_s1 <= dlat[28] ? 29'(-dlat) : 29'(dlat);
			mlon_s1 <= dlon[29] ? 30'(-dlon) : 30'(dlon);
			mla_s1  <= lat_a[27] ? 28'(-lat_a) : 28'(lat_a);
			mlb_s1  <= lat_b[27] ? 28'(-lat_b) : 28'(lat_b);
		end
	end

	// degrees to Q30 radians; differences are halved
	assign p_dlat = {34'b0, mlat_s1} * {30'b0, DEG2RAD_Q38} + 63'd268435456;
	assign p_dlon = {33'b0, mlon_s1} * {30'b0, DEG2RAD_Q38} + 63'd268435456;
	assign p_la   = {35'b0, mla_s1} * {30'b0, DEG2RAD_Q38} + 63'd134217728;
	assign p_lb   = {35'b0, mlb_s1} * {30'b0, DEG2RAD_Q38} + 63'd134217728;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			ang_s2[0] <= p_dlat[29 +: ANG_W];
			ang_s2[1] <= p_dlon[29 +: ANG_W];
			ang_s2[2] <= p_la[28 +: ANG_W];
			ang_s2[3] <= p_lb[28 +: ANG_W];
		end
	end

	assign trig_ctl = '{en: pipe_en, vld: vld_s2};

	hd_trig u_trig (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (trig_ctl),
		.ang     (ang_s2),
		.out_vld (trig_vld),
		.res     (trig)
	);

	// squares and cosine product
	assign sq_lat = trig[0] * trig[0] + 64'sd536870912;
	assign sq_lon = trig[1] * trig[1] + 64'sd536870912;
	assign cos_pr = trig[2] * trig[3] + 64'sd536870912;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			s1sq_s3 <= TW'(sq_lat >>> 30);
			s2sq_s3 <= TW'(sq_lon >>> 30);
			cc_s3   <= TW'(cos_pr >>> 30);
		end
	end

	assign term_pr = cc_s3 * s2sq_s3 + 64'sd536870912;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			s1sq_s4 <= s1sq_s3;
			term_s4 <= TW'(term_pr >>> 30);
		end
	end

	// a clamped to [0, 1]
	assign a_sum = {s1sq_s4[TW-1], s1sq_s4} + {term_s4[TW-1], term_s4};

	always_comb begin
		if (a_sum[TW]) begin
			a_clamp = '0;
		end else if (a_sum > $signed({{(TW-AW+1){1'b0}}, ONE_Q30})) begin
			a_clamp = ONE_Q30;
		end else begin
			a_clamp = a_sum[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			sq_in_s5[0] <= a_clamp;
			sq_in_s5[1] <= ONE_Q30 - a_clamp;
		end
	end

	assign sq_ctl = '{en: pipe_en, vld: vld_s5};

	hd_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (sq_ctl),
		.a_in    (sq_in_s5),
		.out_vld (sq_vld),
		.root    (roots)
	);

	assign at_ctl = '{en: pipe_en, vld: sq_vld};

	hd_atan u_atan (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (at_ctl),
		.x_in    (roots[1]),
		.y_in    (roots[0]),
		.out_vld (at_vld),
		.z_out   (at_z)
	);

	// central angle times calibrated radius
	assign c_ang = at_z[CW-1] ? 33'd0 : {at_z[31:0], 1'b0};

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			prod_s6 <= {29'b0, c_ang} * {33'b0, KM_SCALE_Q16};
		end
	end

	assign d_rnd = prod_s6 + 62'd536870912;
	assign d_km  = d_rnd[61:30];

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			dist_s7 <= (d_km > {1'b0, DIST_MAX}) ? DIST_MAX : d_km[30:0];
		end
	end

endmodule

### design/hd_checker.sv
// ----------------------------------------------------------------------------
// hd_checker
// port-level checks of the haversine pipeline, bound to the top level
// ----------------------------------------------------------------------------
`include "haversine_distance_defines.svh"

module hd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [30:0] distance_km
);
	import hd_pkg::*;

	// saturation keeps every beat in range
	`HD_ASSERT_NOW(a_dist_range, clk, arst_n, out_valid, distance_km <= DIST_MAX, "distance above limit")

	// input back-pressure only from a held output beat
	`HD_ASSERT_NOW(a_stall_src, clk, arst_n, in_stall, out_valid && out_stall, "input stalled without cause")

	// held output beat stays put
	`HD_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(distance_km), "output beat changed under stall")

endmodule

bind haversine_distance hd_checker u_hd_checker (.*);
